// ===== src/pixel_binning_saturating_core_defines.svh =====
// assertion macros for the pixel binning core
`ifndef PIXEL_BINNING_SATURATING_CORE_DEFINES_SVH
`define PIXEL_BINNING_SATURATING_CORE_DEFINES_SVH

// clocked check, held off while reset is asserted
`define PBS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication form of the same check
`define PBS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/pbs_pkg.sv =====
`timescale 1ns / 1ps

package pbs_pkg;

    // line store depth, one entry per possible output column
    localparam int MAX_WIDTH = 4096;
    localparam int CNT_W     = $clog2(MAX_WIDTH);
    localparam int CMP_W     = (CNT_W + 1 > 13) ? CNT_W + 2 : 14;

    localparam int PIX_W     = 16;
    localparam int WIDTH_W   = 13;

    typedef logic [PIX_W-1:0]   t_pix;
    typedef logic [CNT_W-1:0]   t_col;
    typedef logic [CMP_W-1:0]   t_cmp;

    typedef enum logic [1:0] {
        REG_BIN_X      = 2'd0,
        REG_BIN_Y      = 2'd1,
        REG_LINE_WIDTH = 2'd2
    } t_reg_idx;

    localparam logic [WIDTH_W-1:0] LINE_WIDTH_RST = 13'd4096;

    // saturating 16-bit add
    function automatic t_pix sat_add16(input t_pix a, input t_pix b);
        logic [PIX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[PIX_W] ? {PIX_W{1'b1}} : s[PIX_W-1:0];
    endfunction

    // factor minus one as a two-bit mask, code 3 taken as factor 4
    function automatic logic [1:0] factor_mask(input logic [1:0] code);
        logic [1:0] m;
        case (code)
            2'd0:    m = 2'b00;
            2'd1:    m = 2'b01;
            default: m = 2'b11;
        endcase
        return m;
    endfunction

endpackage

// ===== src/pixel_binning_saturating_core.sv =====
`timescale 1ns / 1ps

// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+------------------------------
// pixel in  | in        | i_valid / o_stall    | i_pixel
// binned out| out       | o_valid / i_stall    | o_binned_value, o_row_end
// config    | in        | i_cfg_we             | i_cfg_addr, i_cfg_data
//
// one pixel request per cycle while o_stall is low; the line store is read when a
// group-ending pixel is taken and written back in the cycle after, with the push
// into the output queue; o_valid rises once a finished bin is pushed there
// a read of the entry written in the same cycle is served by a forwarding register
// reset is synchronous, active low; the line store has no reset, every entry is
// written before it is read within a band
// a two-entry output queue absorbs downstream stalls; o_stall rises whenever the
// queue would hold two entries after this cycle's push and pop

module pixel_binning_saturating_core
    import pbs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_addr,
    input  logic [WIDTH_W-1:0]  i_cfg_data,
    input  logic                i_valid,
    input  logic [PIX_W-1:0]    i_pixel,
    output logic                o_stall,
    output logic                o_valid,
    output logic [PIX_W-1:0]    o_binned_value,
    output logic                o_row_end,
    input  logic                i_stall
);

`include "pixel_binning_saturating_core_defines.svh"

    // configuration registers
    logic [1:0]          r_bin_x;
    logic [1:0]          r_bin_y;
    logic [WIDTH_W-1:0]  r_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_x <= 2'd1;
            r_bin_y <= 2'd1;
            r_width <= LINE_WIDTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_BIN_X:      r_bin_x <= i_cfg_data[1:0];
                REG_BIN_Y:      r_bin_y <= i_cfg_data[1:0];
                REG_LINE_WIDTH: r_width <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective settings
    logic [1:0] bx;
    logic [1:0] fx_mask;
    logic [1:0] fy_mask;
    t_cmp       w_ext;
    t_cmp       w_eff;
    t_cmp       w_last;

    always_comb begin
        bx      = (r_bin_x > 2'd2) ? 2'd2 : r_bin_x;
        fx_mask = factor_mask(r_bin_x);
        fy_mask = factor_mask(r_bin_y);
        w_ext   = t_cmp'(r_width);
        if (w_ext == '0)
            w_eff = t_cmp'(1);
        else if (w_ext > t_cmp'(MAX_WIDTH))
            w_eff = t_cmp'(MAX_WIDTH);
        else
            w_eff = w_ext;
        w_last  = w_eff - t_cmp'(1);
    end

    // stream position and running horizontal sum
    t_col       r_col;
    logic [1:0] r_row;
    t_pix       r_hsum;

    logic       in_acc;
    logic       last_col;
    logic       last_row;
    logic       group_end;
    t_pix       hsum_sum;
    t_col       oc;

    always_comb begin
        last_col  = t_cmp'(r_col) >= w_last;
        last_row  = r_row >= fy_mask;
        group_end = ((r_col[1:0] & fx_mask) == fx_mask) || last_col;
        hsum_sum  = sat_add16(r_hsum, i_pixel);
        oc        = r_col >> bx;
    end

    assign in_acc = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_hsum <= '0;
        end else if (in_acc) begin
            r_hsum <= group_end ? '0 : hsum_sum;
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? 2'd0 : r_row + 2'd1;
            end else begin
                r_col <= r_col + t_col'(1);
            end
        end
    end

    // write-back stage: one entry per finished horizontal group
    logic  r_s1_valid;
    logic  r_s1_first;
    logic  r_s1_emit;
    logic  r_s1_end;
    t_col  r_s1_addr;
    t_pix  r_s1_hsum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc && group_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && group_end) begin
            r_s1_first <= (r_row == 2'd0);
            r_s1_emit  <= last_row;
            r_s1_end   <= last_col;
            r_s1_addr  <= oc;
            r_s1_hsum  <= hsum_sum;
        end
    end

    // line store of partial column sums
    t_pix  r_mem [MAX_WIDTH];
    t_pix  r_mem_q;
    logic  r_fwd;
    t_pix  r_fwd_val;

    logic  wr_en;
    t_pix  col_old;
    t_pix  v;

    always_comb begin
        wr_en   = r_s1_valid;
        col_old = r_fwd ? r_fwd_val : r_mem_q;
        v       = r_s1_first ? r_s1_hsum : sat_add16(col_old, r_s1_hsum);
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && group_end)
            r_mem_q <= r_mem[oc];
        if (wr_en)
            r_mem[r_s1_addr] <= v;
    end

    // a read of the entry being written this cycle sees the old data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (in_acc && group_end) begin
            r_fwd <= wr_en && (r_s1_addr == oc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && group_end)
            r_fwd_val <= v;
    end

    // two-entry output queue
    t_pix       r_q_val [2];
    logic       r_q_end [2];
    logic       r_q_head;
    logic [1:0] r_q_cnt;

    logic       push;
    logic       pop;
    logic       tail;
    logic [1:0] cnt_after;

    always_comb begin
        push      = r_s1_valid && r_s1_emit;
        pop       = o_valid && !i_stall;
        tail      = r_q_head ^ r_q_cnt[0];
        cnt_after = r_q_cnt - {1'b0, pop} + {1'b0, push};
    end

    // a request taken now reaches the queue only through the write-back stage
    assign o_stall = cnt_after >= 2'd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_head <= 1'b0;
            r_q_cnt  <= '0;
        end else begin
            r_q_cnt <= cnt_after;
            if (pop)
                r_q_head <= ~r_q_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_val[tail] <= v;
            r_q_end[tail] <= r_s1_end;
        end
    end

    assign o_valid        = r_q_cnt != 2'd0;
    assign o_binned_value = r_q_val[r_q_head];
    assign o_row_end      = r_q_end[r_q_head];

    // checks
    `PBS_ASSERT(a_q_bound, r_q_cnt <= 2'd2, "output queue over two entries")
    `PBS_ASSERT_IMP(a_no_overflow, push && !pop, r_q_cnt < 2'd2,
        "result pushed into a full output queue")
    `PBS_ASSERT_IMP(a_row_wrap, in_acc && last_col, ##1 (r_col == '0),
        "column count not cleared at end of row")
    `PBS_ASSERT_IMP(a_fwd_src, r_s1_valid && r_fwd, $past(r_s1_valid),
        "forwarding without a write-back")

endmodule
